// ===== sv/csc_pkg.sv =====
// csc_pkg: shared constants, types and helper functions of the color space converter
// no dependencies; used by the interfaces, csc_div and color_space_converter
package csc_pkg;

	localparam int CH_W       = 8;
	localparam int SP_W       = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int PIPE_DEPTH = 11;

	// space codes
	localparam logic [SP_W-1:0] SP_RGB   = 3'd0;
	localparam logic [SP_W-1:0] SP_HSL   = 3'd1;
	localparam logic [SP_W-1:0] SP_HSV   = 3'd2;
	localparam logic [SP_W-1:0] SP_Y601  = 3'd3;
	localparam logic [SP_W-1:0] SP_Y709  = 3'd4;
	localparam logic [SP_W-1:0] SP_YCOCG = 3'd5;
	localparam logic [SP_W-1:0] SP_CMY   = 3'd6;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SRC = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TGT = 1'b1;

	// divider geometry
	localparam int DIV_NUM_W  = 19;
	localparam int DIV_DEN_W  = 11;
	localparam int DIV_Q_W    = 8;
	localparam int DIV_STAGES = 4;
	localparam int DIV_BPS    = DIV_Q_W / DIV_STAGES;

	localparam logic [23:0] HALF_Q  = 24'd8355840;
	localparam logic [31:0] RCP_255 = 32'h80808081;

	typedef logic [2:0][CH_W-1:0] px_t;

	typedef struct packed {
		logic [15:0] ar;
		logic [15:0] ab;
		logic [15:0] gb;
		logic [15:0] gr;
		logic [15:0] kr;
		logic [15:0] kg;
		logic [15:0] kb;
		logic [15:0] cbk;
		logic [15:0] crk;
	} ycc_coef_t;

	localparam ycc_coef_t YCC_601 = '{ar: 16'd45941, ab: 16'd58065, gb: 16'd11277,
		gr: 16'd23401, kr: 16'd19595, kg: 16'd38470, kb: 16'd7471, cbk: 16'd36984,
		crk: 16'd46745};
	localparam ycc_coef_t YCC_709 = '{ar: 16'd51603, ab: 16'd60804, gb: 16'd6138,
		gr: 16'd15339, kr: 16'd13933, kg: 16'd46871, kb: 16'd4732, cbk: 16'd35318,
		crk: 16'd41615};

	typedef struct packed {
		px_t  px;
		logic hz;
		logic sz;
	} side_t;

	// floor(x/255) for x below 65280
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
		return t[15:8];
	endfunction

	// Q16 value to a channel, clipped to 0..255
	function automatic logic [7:0] sat16(input logic signed [31:0] q);
		logic [7:0] r;
		if (q[31])
			r = 8'd0;
		else if (|q[30:24])
			r = 8'hFF;
		else
			r = q[23:16];
		return r;
	endfunction

	function automatic logic [7:0] sat8(input logic signed [11:0] v);
		logic [7:0] r;
		if (v[11])
			r = 8'd0;
		else if (|v[10:8])
			r = 8'hFF;
		else
			r = v[7:0];
		return r;
	endfunction

endpackage

// ===== sv/csc_in_if.sv =====
// csc_in_if: input pixel channel, valid/ready handshake with three channel fields
// depends on csc_pkg
interface csc_in_if;
	logic                     valid;
	logic                     ready;
	logic [csc_pkg::CH_W-1:0] chan_a;
	logic [csc_pkg::CH_W-1:0] chan_b;
	logic [csc_pkg::CH_W-1:0] chan_c;

	modport source(output valid, chan_a, chan_b, chan_c, input ready);
	modport sink(input valid, chan_a, chan_b, chan_c, output ready);
endinterface

// ===== sv/csc_out_if.sv =====
// csc_out_if: result pixel channel, valid/ready handshake with three channel fields
// depends on csc_pkg
interface csc_out_if;
	logic                     valid;
	logic                     ready;
	logic [csc_pkg::CH_W-1:0] out_a;
	logic [csc_pkg::CH_W-1:0] out_b;
	logic [csc_pkg::CH_W-1:0] out_c;

	modport source(output valid, out_a, out_b, out_c, input ready);
	modport sink(input valid, out_a, out_b, out_c, output ready);
endinterface

// ===== sv/color_space_converter.sv =====
// color_space_converter: top level, source space -> RGB -> target space, one pixel a clock
// depends on csc_pkg, csc_in_if, csc_out_if and csc_div
//
// Usage: pixels enter on pix_in (chan_a/b/c) and leave on pix_out (out_a/b/c), both
// valid/ready. source_space and target_space are set through cfg_we/cfg_idx/cfg_data
// (index 0 source, index 1 target) while no pixel is in flight.
// A word accepted on pix_in passes through every stage in order to the output register.
// Throughput: one word per clock; the 11-stage pipeline holds up to 11 words. The
// deepest work per stage is one multiplier (a 32x32 reciprocal multiply for the hue
// interpolation) or two quotient bits of the hue/saturation dividers.
// Stall: when the output register holds a word that is not taken, the whole pipeline
// freezes and pix_in.ready drops; nothing is lost or repeated, and the output word
// stays until taken. Bubbles travel with their valid bits.
// Reset: arst_n clears all valid bits and sets both spaces to RGB (pass-through).
module color_space_converter (
	input  logic                          clk,
	input  logic                          arst_n,
	csc_in_if.sink                        pix_in,
	csc_out_if.source                     pix_out,
	input  logic                          cfg_we,
	input  logic [csc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [csc_pkg::SP_W-1:0]      cfg_data
);

	logic [csc_pkg::SP_W-1:0]       src_q;
	logic [csc_pkg::SP_W-1:0]       tgt_q;
	logic [csc_pkg::PIPE_DEPTH-1:0] vld_q;
	logic                           en;
	csc_pkg::ycc_coef_t             ks;
	csc_pkg::ycc_coef_t             kt;

	assign en           = !vld_q[csc_pkg::PIPE_DEPTH-1] || pix_out.ready;
	assign pix_in.ready = en;
	assign ks = (src_q == csc_pkg::SP_Y709) ? csc_pkg::YCC_709 : csc_pkg::YCC_601;
	assign kt = (tgt_q == csc_pkg::SP_Y709) ? csc_pkg::YCC_709 : csc_pkg::YCC_601;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= csc_pkg::SP_RGB;
			tgt_q <= csc_pkg::SP_RGB;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				csc_pkg::CFG_SRC: src_q <= cfg_data;
				csc_pkg::CFG_TGT: tgt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[csc_pkg::PIPE_DEPTH-2:0], pix_in.valid};
	end

	// ---------------- stage 1: chroma product, hue sector, ycc products
	logic [8:0]               c2;
	logic [7:0]               hsl_base;
	logic [7:0]               base;
	logic [10:0]              h6;
	logic [10:0]              h6m1;
	logic [7:0]               sec_raw;
	logic [7:0]               q2;
	logic [9:0]               t10;
	logic signed [9:0]        cb2;
	logic signed [9:0]        cr2;
	logic signed [11:0]       ia;
	logic signed [11:0]       ib;
	logic signed [11:0]       ic;
	csc_pkg::px_t             simple1;

	logic [15:0]              p_s1;
	logic [2:0]               sec_s1;
	logic [7:0]               w_s1;
	logic [7:0]               a_s1;
	logic [7:0]               c_s1;
	logic signed [26:0]       prr_s1;
	logic signed [26:0]       pgb_s1;
	logic signed [26:0]       pgr_s1;
	logic signed [26:0]       pbb_s1;
	csc_pkg::px_t             rgb_s1;

	always_comb begin
		c2       = {pix_in.chan_c, 1'b0};
		hsl_base = (c2 >= 9'd255) ? 8'(9'd510 - c2) : c2[7:0];
		base     = (src_q == csc_pkg::SP_HSL) ? hsl_base : pix_in.chan_c;
		h6       = 11'(pix_in.chan_a) * 11'd6;
		h6m1     = h6 - 11'd1;
		sec_raw  = csc_pkg::div255({5'b0, h6m1});
		q2       = csc_pkg::div255({5'b0, h6});
		t10      = 10'(h6 - 11'd510 * 11'(q2[7:1]));
		cb2      = $signed({1'b0, pix_in.chan_b, 1'b0}) - 10'sd255;
		cr2      = $signed({1'b0, pix_in.chan_c, 1'b0}) - 10'sd255;
		ia       = $signed({4'b0, pix_in.chan_a});
		ib       = $signed({4'b0, pix_in.chan_b});
		ic       = $signed({4'b0, pix_in.chan_c});
		case (src_q)
			csc_pkg::SP_YCOCG: begin
				simple1[0] = csc_pkg::sat8(ia + ib - ic);
				simple1[1] = csc_pkg::sat8(ia + ic - 12'sd128);
				simple1[2] = csc_pkg::sat8(ia - ib - ic + 12'sd255);
			end
			csc_pkg::SP_CMY: begin
				simple1[0] = ~pix_in.chan_a;
				simple1[1] = ~pix_in.chan_b;
				simple1[2] = ~pix_in.chan_c;
			end
			default: begin
				simple1[0] = pix_in.chan_a;
				simple1[1] = pix_in.chan_b;
				simple1[2] = pix_in.chan_c;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1   <= base * pix_in.chan_b;
			if (h6 == 11'd0)
				sec_s1 <= 3'd0;
			else if (sec_raw > 8'd5)
				sec_s1 <= 3'd5;
			else
				sec_s1 <= sec_raw[2:0];
			w_s1   <= (t10 >= 10'd255) ? 8'(10'd510 - t10) : t10[7:0];
			a_s1   <= pix_in.chan_a;
			c_s1   <= pix_in.chan_c;
			prr_s1 <= cr2 * $signed({1'b0, ks.ar});
			pgb_s1 <= cb2 * $signed({1'b0, ks.gb});
			pgr_s1 <= cr2 * $signed({1'b0, ks.gr});
			pbb_s1 <= cb2 * $signed({1'b0, ks.ab});
			rgb_s1 <= simple1;
		end
	end

	// ---------------- stage 2: chroma in Q16, offset m, ycc sums
	logic [23:0]        cq2;
	logic [23:0]        cfull;
	logic signed [28:0] yq2;
	logic signed [28:0] rr2;
	logic signed [28:0] gg2;
	logic signed [28:0] bb2;

	logic [23:0]        cq_s2;
	logic signed [25:0] mq_s2;
	logic [2:0]         sec_s2;
	logic [7:0]         w_s2;
	csc_pkg::px_t       rgb_s2;

	always_comb begin
		cq2   = 24'({p_s1, 8'b0}) + 24'(p_s1) + 24'(csc_pkg::div255(p_s1));
		cfull = {c_s1, 16'b0};
		yq2   = $signed({5'b0, a_s1, 16'b0});
		rr2   = yq2 + prr_s1;
		gg2   = yq2 - pgb_s1 - pgr_s1;
		bb2   = yq2 + pbb_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cq_s2  <= cq2;
			if (src_q == csc_pkg::SP_HSL)
				mq_s2 <= $signed({2'b0, cfull}) - $signed({3'b0, cq2[23:1]});
			else
				mq_s2 <= $signed({2'b0, cfull}) - $signed({2'b0, cq2});
			sec_s2 <= sec_s1;
			w_s2   <= w_s1;
			if (src_q == csc_pkg::SP_Y601 || src_q == csc_pkg::SP_Y709) begin
				rgb_s2[0] <= csc_pkg::sat16(32'(rr2));
				rgb_s2[1] <= csc_pkg::sat16(32'(gg2));
				rgb_s2[2] <= csc_pkg::sat16(32'(bb2));
			end else begin
				rgb_s2 <= rgb_s1;
			end
		end
	end

	// ---------------- stage 3: C * w
	logic [31:0]        y_s3;
	logic [23:0]        cq_s3;
	logic signed [25:0] mq_s3;
	logic [2:0]         sec_s3;
	csc_pkg::px_t       rgb_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			y_s3   <= cq_s2 * w_s2;
			cq_s3  <= cq_s2;
			mq_s3  <= mq_s2;
			sec_s3 <= sec_s2;
			rgb_s3 <= rgb_s2;
		end
	end

	// ---------------- stage 4: X = C * w / 255 by reciprocal
	logic [63:0]        xm;
	logic [23:0]        xq_s4;
	logic [23:0]        cq_s4;
	logic signed [25:0] mq_s4;
	logic [2:0]         sec_s4;
	csc_pkg::px_t       rgb_s4;

	assign xm = {32'b0, y_s3} * {32'b0, csc_pkg::RCP_255};

	always_ff @(posedge clk) begin
		if (en) begin
			xq_s4  <= xm[62:39];
			cq_s4  <= cq_s3;
			mq_s4  <= mq_s3;
			sec_s4 <= sec_s3;
			rgb_s4 <= rgb_s3;
		end
	end

	// ---------------- stage 5: sector placement, add m, clip
	logic [2:0][23:0]        v5;
	logic signed [2:0][25:0] sum5;
	csc_pkg::px_t            rgb_s5;

	always_comb begin
		case (sec_s4)
			3'd0:    v5 = {24'd0, xq_s4, cq_s4};
			3'd1:    v5 = {24'd0, cq_s4, xq_s4};
			3'd2:    v5 = {xq_s4, cq_s4, 24'd0};
			3'd3:    v5 = {cq_s4, xq_s4, 24'd0};
			3'd4:    v5 = {cq_s4, 24'd0, xq_s4};
			default: v5 = {xq_s4, 24'd0, cq_s4};
		endcase
		for (int i = 0; i < 3; i++)
			sum5[i] = $signed({2'b0, v5[i]}) + mq_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (src_q == csc_pkg::SP_HSL || src_q == csc_pkg::SP_HSV) begin
				for (int i = 0; i < 3; i++)
					rgb_s5[i] <= csc_pkg::sat16(32'($signed(sum5[i])));
			end else begin
				rgb_s5 <= rgb_s4;
			end
		end
	end

	// ---------------- stage 6: max/min, hue and saturation operands, luma
	logic [7:0]   r6;
	logic [7:0]   g6;
	logic [7:0]   b6;
	logic [7:0]   mx6;
	logic [7:0]   mn6;
	logic [7:0]   d6;
	logic [8:0]   s6;
	logic [10:0]  d6x6;
	logic [10:0]  n6;
	logic [7:0]   den6;
	logic [9:0]   ysum6;
	logic [8:0]   co6;
	logic [10:0]  cg6;
	csc_pkg::px_t simple6;

	logic [csc_pkg::DIV_NUM_W-1:0] hnum_s6;
	logic [csc_pkg::DIV_DEN_W-1:0] hden_s6;
	logic [csc_pkg::DIV_NUM_W-1:0] snum_s6;
	logic [csc_pkg::DIV_DEN_W-1:0] sden_s6;
	logic [23:0]                   yq_s6;
	logic [7:0]                    r_s6;
	logic [7:0]                    b_s6;
	csc_pkg::side_t                side_s6;

	always_comb begin
		r6   = rgb_s5[0];
		g6   = rgb_s5[1];
		b6   = rgb_s5[2];
		mx6  = r6;
		mn6  = r6;
		if (g6 > mx6) mx6 = g6;
		if (b6 > mx6) mx6 = b6;
		if (g6 < mn6) mn6 = g6;
		if (b6 < mn6) mn6 = b6;
		d6   = mx6 - mn6;
		s6   = 9'(mx6) + 9'(mn6);
		d6x6 = 11'({d6, 2'b0}) + 11'({d6, 1'b0});
		if (mx6 == r6)
			n6 = (g6 >= b6) ? 11'(g6 - b6) : d6x6 - 11'(b6 - g6);
		else if (mx6 == g6)
			n6 = 11'({d6, 1'b0}) + 11'(b6) - 11'(r6);
		else
			n6 = 11'({d6, 2'b0}) + 11'(r6) - 11'(g6);
		if (tgt_q == csc_pkg::SP_HSL)
			den6 = (s6 <= 9'd255) ? s6[7:0] : 8'(9'd510 - s6);
		else
			den6 = mx6;
		ysum6 = 10'(r6) + 10'({g6, 1'b0}) + 10'(b6);
		co6   = 9'(r6) + 9'd255 - 9'(b6);
		cg6   = 11'({g6, 1'b0}) + 11'd510 - 11'(r6) - 11'(b6);
		case (tgt_q)
			csc_pkg::SP_HSL: simple6 = {s6[8:1], 8'd0, 8'd0};
			csc_pkg::SP_HSV: simple6 = {mx6, 8'd0, 8'd0};
			csc_pkg::SP_YCOCG: simple6 = {cg6[9:2], co6[8:1], ysum6[9:2]};
			csc_pkg::SP_CMY: simple6 = {~b6, ~g6, ~r6};
			default: simple6 = rgb_s5;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hnum_s6    <= csc_pkg::DIV_NUM_W'({n6, 8'b0}) - csc_pkg::DIV_NUM_W'(n6);
			hden_s6    <= d6x6;
			snum_s6    <= csc_pkg::DIV_NUM_W'({d6, 8'b0}) - csc_pkg::DIV_NUM_W'(d6);
			sden_s6    <= csc_pkg::DIV_DEN_W'(den6);
			yq_s6      <= 24'(kt.kr) * 24'(r6) + 24'(kt.kg) * 24'(g6)
				+ 24'(kt.kb) * 24'(b6);
			r_s6       <= r6;
			b_s6       <= b6;
			side_s6.px <= simple6;
			side_s6.hz <= (d6 == 8'd0);
			side_s6.sz <= (den6 == 8'd0);
		end
	end

	// ---------------- stages 7 to 10: dividers, chroma products and side data
	logic [csc_pkg::DIV_Q_W-1:0] hue_q;
	logic [csc_pkg::DIV_Q_W-1:0] sat_q;

	csc_div u_hue_div (
		.clk (clk),
		.en  (en),
		.num (hnum_s6),
		.den (hden_s6),
		.quo (hue_q)
	);

	csc_div u_sat_div (
		.clk (clk),
		.en  (en),
		.num (snum_s6),
		.den (sden_s6),
		.quo (sat_q)
	);

	logic signed [24:0] cbv7;
	logic signed [24:0] crv7;
	logic signed [41:0] cbp_s7;
	logic signed [41:0] crp_s7;
	logic [23:0]        yq_s7;
	csc_pkg::side_t     side_s7;

	assign cbv7 = $signed({1'b0, b_s6, 16'b0}) - $signed({1'b0, yq_s6});
	assign crv7 = $signed({1'b0, r_s6, 16'b0}) - $signed({1'b0, yq_s6});

	always_ff @(posedge clk) begin
		if (en) begin
			cbp_s7  <= cbv7 * $signed({1'b0, kt.cbk});
			crp_s7  <= crv7 * $signed({1'b0, kt.crk});
			yq_s7   <= yq_s6;
			side_s7 <= side_s6;
		end
	end

	logic signed [25:0] cbs8;
	logic signed [25:0] crs8;
	logic signed [26:0] cbh8;
	logic signed [26:0] crh8;
	csc_pkg::side_t     side8;
	csc_pkg::side_t     side_s8;
	csc_pkg::side_t     side_s9;
	csc_pkg::side_t     side_s10;

	always_comb begin
		cbs8  = 26'(cbp_s7 >>> 16);
		crs8  = 26'(crp_s7 >>> 16);
		cbh8  = cbs8 + $signed({1'b0, csc_pkg::HALF_Q});
		crh8  = crs8 + $signed({1'b0, csc_pkg::HALF_Q});
		side8 = side_s7;
		if (tgt_q == csc_pkg::SP_Y601 || tgt_q == csc_pkg::SP_Y709) begin
			side8.px[0] = csc_pkg::sat16($signed({8'b0, yq_s7}));
			side8.px[1] = csc_pkg::sat16(32'(cbh8));
			side8.px[2] = csc_pkg::sat16(32'(crh8));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s8  <= side8;
			side_s9  <= side_s8;
			side_s10 <= side_s9;
		end
	end

	// ---------------- stage 11: output register
	csc_pkg::px_t res11;
	csc_pkg::px_t res_s11;

	always_comb begin
		res11 = side_s10.px;
		if (tgt_q == csc_pkg::SP_HSL || tgt_q == csc_pkg::SP_HSV) begin
			res11[0] = side_s10.hz ? 8'd0 : hue_q;
			res11[1] = side_s10.sz ? 8'd0 : sat_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			res_s11 <= res11;
	end

	assign pix_out.valid = vld_q[csc_pkg::PIPE_DEPTH-1];
	assign pix_out.out_a = res_s11[0];
	assign pix_out.out_b = res_s11[1];
	assign pix_out.out_c = res_s11[2];

	// accepted word enters the first stage
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_in.valid && pix_in.ready) |=> vld_q[0])
		else $error("accepted word missing from first stage");

	// a stall freezes the whole pipeline
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved during stall");

	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pix_out.valid) |-> $past(vld_q[csc_pkg::PIPE_DEPTH-2]))
		else $error("output word without a word in the last stage");

	// gray pixels give zero hue
	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_q[csc_pkg::PIPE_DEPTH-2] && side_s10.hz
			&& (tgt_q == csc_pkg::SP_HSL || tgt_q == csc_pkg::SP_HSV))
		|=> pix_out.out_a == 8'd0)
		else $error("gray pixel with nonzero hue");

endmodule

// ===== sv/csc_div.sv =====
// csc_div: pipelined restoring divider, 8-bit quotient, two quotient bits per stage
// depends on csc_pkg; quotient must fit in 8 bits
module csc_div (
	input  logic                            clk,
	input  logic                            en,
	input  logic [csc_pkg::DIV_NUM_W-1:0]   num,
	input  logic [csc_pkg::DIV_DEN_W-1:0]   den,
	output logic [csc_pkg::DIV_Q_W-1:0]     quo
);

	logic [csc_pkg::DIV_NUM_W-1:0] rem_s [csc_pkg::DIV_STAGES];
	logic [csc_pkg::DIV_DEN_W-1:0] den_s [csc_pkg::DIV_STAGES];
	logic [csc_pkg::DIV_Q_W-1:0]   quo_s [csc_pkg::DIV_STAGES];

	for (genvar k = 0; k < csc_pkg::DIV_STAGES; k++) begin : g_stg
		logic [csc_pkg::DIV_NUM_W-1:0] r_in;
		logic [csc_pkg::DIV_NUM_W-1:0] r_n;
		logic [csc_pkg::DIV_NUM_W-1:0] sub;
		logic [csc_pkg::DIV_DEN_W-1:0] d_in;
		logic [csc_pkg::DIV_Q_W-1:0]   q_in;
		logic [csc_pkg::DIV_Q_W-1:0]   q_n;

		if (k == 0) begin : g_first
			assign r_in = num;
			assign d_in = den;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_s[k-1];
			assign d_in = den_s[k-1];
			assign q_in = quo_s[k-1];
		end

		always_comb begin
			r_n = r_in;
			q_n = q_in;
			sub = '0;
			for (int j = 0; j < csc_pkg::DIV_BPS; j++) begin
				sub = csc_pkg::DIV_NUM_W'(d_in)
					<< (csc_pkg::DIV_Q_W - 1 - k * csc_pkg::DIV_BPS - j);
				if (r_n >= sub) begin
					r_n = r_n - sub;
					q_n[csc_pkg::DIV_Q_W - 1 - k * csc_pkg::DIV_BPS - j] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= r_n;
				den_s[k] <= d_in;
				quo_s[k] <= q_n;
			end
		end
	end

	assign quo = quo_s[csc_pkg::DIV_STAGES-1];

endmodule
